### hw/rtl/hrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrb_pkg
// Shared types, codes and sizes of the hit region binner.
// ----------------------------------------------------------------------------
package hrb_pkg;

  localparam int HIT_CAPACITY = 256;
  localparam int ADDR_W       = $clog2(HIT_CAPACITY);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int X_BINS       = 4;
  localparam int Y_BANDS      = 4;
  localparam int REGIONS      = X_BINS * Y_BANDS;
  localparam int SLOTS        = REGIONS + 1;
  localparam int REG_W        = 4;
  localparam int BIN_W        = 2;
  localparam int NB_W         = 3;
  localparam int HIT_W        = 60;
  localparam int KEY_W        = REG_W + 16;
  localparam int WORK_W       = KEY_W + HIT_W;
  localparam int TUPLE_W      = KEY_W + ADDR_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // command codes of the input word
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;
  localparam logic [2:0] CMD_BUILD   = 3'd2;
  localparam logic [2:0] CMD_QREGION = 3'd3;
  localparam logic [2:0] CMD_QMIN    = 3'd4;
  localparam logic [2:0] CMD_QWIN    = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  // status codes of the result word
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_BUILT = 3'd2;
  localparam logic [2:0] ST_BAD       = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_UB0    = 3'd0;
  localparam logic [2:0] CFG_UB1    = 3'd1;
  localparam logic [2:0] CFG_UB2    = 3'd2;
  localparam logic [2:0] CFG_UB3    = 3'd3;
  localparam logic [2:0] CFG_NBINS  = 3'd4;
  localparam logic [2:0] CFG_YBASE  = 3'd5;
  localparam logic [2:0] CFG_YSTEP  = 3'd6;

  typedef enum logic [2:0] {
    OP_CLEAR, OP_LOAD, OP_BUILD, OP_QREGION, OP_QMIN, OP_QWIN, OP_READ, OP_NOP
  } op_t;

  typedef struct packed {
    logic [15:0] x;
    logic [11:0] dx;
    logic [15:0] y;
    logic [15:0] tag;
  } hit_t;

  typedef struct packed {
    op_t         op;
    hit_t        hit;
    logic [3:0]  region;
    logic [15:0] x_min;
    logic [15:0] x_max;
    logic [7:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [CNT_W-1:0] first_index;
    logic [CNT_W-1:0] end_index;
    hit_t             hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] dropped_count;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_QA, S_QB, S_MIN_RD, S_MIN_CHK, S_MAX_RD, S_MAX_CHK,
    S_CL_RD, S_CL_CHK, S_SEL_INIT, S_SEL_RD, S_SEL_CHK, S_DONE
  } bst_t;

endpackage
`default_nettype wire

### hw/rtl/hrb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrb_in_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface hrb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] hit_x;
  logic [11:0] hit_width;
  logic [15:0] hit_y;
  logic [15:0] hit_tag;
  logic [3:0]  region;
  logic [15:0] x_min;
  logic [15:0] x_max;
  logic [7:0]  read_index;

  modport source (output valid, cmd, hit_x, hit_width, hit_y, hit_tag, region,
                  x_min, x_max, read_index, input ready);
  modport sink (input valid, cmd, hit_x, hit_width, hit_y, hit_tag, region,
                x_min, x_max, read_index, output ready);
endinterface
`default_nettype wire

### hw/rtl/hrb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrb_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface hrb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [8:0]  first_index;
  logic [8:0]  end_index;
  logic [15:0] out_x;
  logic [11:0] out_width;
  logic [15:0] out_y;
  logic [15:0] out_tag;
  logic [8:0]  hit_count;
  logic [8:0]  dropped_count;

  modport source (output valid, status, first_index, end_index, out_x, out_width,
                  out_y, out_tag, hit_count, dropped_count, input ready);
  modport sink (input valid, status, first_index, end_index, out_x, out_width,
                out_y, out_tag, hit_count, dropped_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/hrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/hrb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrb_front
// Accepts command words and decodes them into internal operations.
// ----------------------------------------------------------------------------
module hrb_front (
  hrb_in_if.sink            in_ch,
  output logic              push_valid,
  output hrb_pkg::item_t    push_item,
  input  wire logic         push_ready
);

  // accept whenever the queue has room
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  // decode the command and pack the word
  always_comb begin
    push_item            = '0;
    push_item.hit.x      = in_ch.hit_x;
    push_item.hit.dx     = in_ch.hit_width;
    push_item.hit.y      = in_ch.hit_y;
    push_item.hit.tag    = in_ch.hit_tag;
    push_item.region     = in_ch.region;
    push_item.x_min      = in_ch.x_min;
    push_item.x_max      = in_ch.x_max;
    push_item.read_index = in_ch.read_index;
    case (in_ch.cmd)
      hrb_pkg::CMD_CLEAR:   push_item.op = hrb_pkg::OP_CLEAR;
      hrb_pkg::CMD_LOAD:    push_item.op = hrb_pkg::OP_LOAD;
      hrb_pkg::CMD_BUILD:   push_item.op = hrb_pkg::OP_BUILD;
      hrb_pkg::CMD_QREGION: push_item.op = hrb_pkg::OP_QREGION;
      hrb_pkg::CMD_QMIN:    push_item.op = hrb_pkg::OP_QMIN;
      hrb_pkg::CMD_QWIN:    push_item.op = hrb_pkg::OP_QWIN;
      hrb_pkg::CMD_READ:    push_item.op = hrb_pkg::OP_READ;
      default:              push_item.op = hrb_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/hrb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrb_queue
// Two-entry queue of decoded words between front and back.
// ----------------------------------------------------------------------------
module hrb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  hrb_pkg::item_t      push_item,
  output logic                push_ready,
  output logic                pop_valid,
  output hrb_pkg::item_t      pop_item,
  input  wire logic           pop
);

  hrb_pkg::item_t mem_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // advance pointers and fill level
  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold the payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/hrb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrb_back
// Executes words one at a time: store access, build sort and range scans.
// ----------------------------------------------------------------------------
module hrb_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [hrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hrb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            pop_valid,
  input  hrb_pkg::item_t                       pop_item,
  output logic                                 pop,
  output logic                                 res_valid,
  output hrb_pkg::result_t                     res,
  input  wire logic                            res_ready
);

  localparam int AW = hrb_pkg::ADDR_W;
  localparam int CW = hrb_pkg::CNT_W;

  hrb_pkg::bst_t    state_r, state_nxt;
  hrb_pkg::item_t   item_r, item_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt, drop_r, drop_nxt;
  logic             built_r, built_nxt;
  logic [CW-1:0]    rs_r [hrb_pkg::SLOTS];
  logic [CW-1:0]    rs_nxt [hrb_pkg::SLOTS];
  logic [15:0]      ub_r [hrb_pkg::X_BINS];
  logic [15:0]      ub_nxt [hrb_pkg::X_BINS];
  logic [2:0]       nbins_r, nbins_nxt;
  logic [15:0]      ybase_r, ybase_nxt;
  logic [14:0]      ystep_r, ystep_nxt;
  logic [CW-1:0]    idx_r, idx_nxt, p_r, p_nxt, kept_r, kept_nxt, dcnt_r, dcnt_nxt;
  logic [CW-1:0]    first_r, first_nxt, last_r, last_nxt, end_r, end_nxt;
  logic [hrb_pkg::TUPLE_W-1:0] best_key_r, best_key_nxt, last_key_r, last_key_nxt;
  hrb_pkg::hit_t    best_hit_r, best_hit_nxt;
  logic             best_none_r, best_none_nxt, last_none_r, last_none_nxt;
  logic [2:0]       pstat_r, pstat_nxt;
  hrb_pkg::hit_t    phit_r, phit_nxt;
  logic             ov_r, ov_nxt;
  hrb_pkg::result_t res_r, res_nxt;

  logic                        st_we, wk_we;
  logic [AW-1:0]               st_waddr, st_raddr, wk_waddr, wk_raddr;
  logic [hrb_pkg::HIT_W-1:0]   st_wdata, st_rdata;
  logic [hrb_pkg::WORK_W-1:0]  wk_wdata, wk_rdata;

  hrb_pkg::hit_t               st_hit, wk_hit;
  logic [hrb_pkg::KEY_W-1:0]   wk_key, cl_key;
  logic [hrb_pkg::TUPLE_W-1:0] tup;
  logic [hrb_pkg::NB_W-1:0]    nb;
  logic [hrb_pkg::BIN_W-1:0]   bin;
  logic [hrb_pkg::REG_W-1:0]   band;
  logic                        bin_ok, band_ok;
  logic [19:0]                 edge_v, step_mul, y_ext;
  logic [17:0]                 lhs_min, rhs_min;
  logic [9:0]                  drop_sum;
  logic [hrb_pkg::REG_W-1:0]   last_rg, best_rg;

  hrb_ram #(.WIDTH(hrb_pkg::HIT_W), .DEPTH(hrb_pkg::HIT_CAPACITY)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  hrb_ram #(.WIDTH(hrb_pkg::WORK_W), .DEPTH(hrb_pkg::HIT_CAPACITY)) u_work (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wk_rdata)
  );

  assign st_hit    = st_rdata;
  assign wk_hit    = wk_rdata[hrb_pkg::HIT_W-1:0];
  assign wk_key    = wk_rdata[hrb_pkg::WORK_W-1:hrb_pkg::HIT_W];
  assign tup       = {wk_key, idx_r[AW-1:0]};
  assign last_rg   = last_key_r[hrb_pkg::TUPLE_W-1 -: hrb_pkg::REG_W];
  assign best_rg   = best_key_r[hrb_pkg::TUPLE_W-1 -: hrb_pkg::REG_W];
  assign res_valid = ov_r;
  assign res       = res_r;

  // clamp the bin count
  always_comb begin
    if (nbins_r < 3'd1) begin
      nb = 3'd1;
    end else if (nbins_r > 3'(hrb_pkg::X_BINS)) begin
      nb = 3'(hrb_pkg::X_BINS);
    end else begin
      nb = nbins_r;
    end
  end

  // classify the hit read from the store
  always_comb begin
    bin     = '0;
    bin_ok  = 1'b0;
    band    = '0;
    band_ok = 1'b0;
    edge_v  = '0;
    step_mul = '0;
    y_ext   = {{4{st_hit.y[15]}}, st_hit.y};
    for (int b = 0; b < hrb_pkg::X_BINS; b++) begin
      if (!bin_ok && (3'(b) < nb) && ($signed(st_hit.x) < $signed(ub_r[b]))) begin
        bin    = hrb_pkg::BIN_W'(b);
        bin_ok = 1'b1;
      end
    end
    for (int j = 0; j < hrb_pkg::Y_BANDS; j++) begin
      step_mul = 20'(ystep_r) * 20'(j + 1);
      edge_v   = {{4{ybase_r[15]}}, ybase_r} + step_mul;
      if (!band_ok && ($signed(y_ext) < $signed(edge_v))) begin
        band    = hrb_pkg::REG_W'(j);
        band_ok = 1'b1;
      end
    end
    cl_key = {hrb_pkg::REG_W'(bin * hrb_pkg::Y_BANDS + band),
              st_hit.x ^ 16'h8000};
  end

  // exact test x + dx/2 > x_min as 2x + dx > 2 x_min
  assign lhs_min  = {st_hit.x[15], st_hit.x, 1'b0} + {6'b0, st_hit.dx};
  assign rhs_min  = {item_r.x_min[15], item_r.x_min, 1'b0};
  assign drop_sum = {1'b0, drop_r} + {1'b0, dcnt_r};

  // sequencer: next state, RAM controls and result
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    built_nxt     = built_r;
    rs_nxt        = rs_r;
    ub_nxt        = ub_r;
    nbins_nxt     = nbins_r;
    ybase_nxt     = ybase_r;
    ystep_nxt     = ystep_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    kept_nxt      = kept_r;
    dcnt_nxt      = dcnt_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    end_nxt       = end_r;
    best_key_nxt  = best_key_r;
    best_hit_nxt  = best_hit_r;
    best_none_nxt = best_none_r;
    last_key_nxt  = last_key_r;
    last_none_nxt = last_none_r;
    pstat_nxt     = pstat_r;
    phit_nxt      = phit_r;
    ov_nxt        = ov_r;
    res_nxt       = res_r;
    pop           = 1'b0;
    st_we         = 1'b0;
    st_waddr      = cnt_r[AW-1:0];
    st_wdata      = item_r.hit;
    st_raddr      = idx_r[AW-1:0];
    wk_we         = 1'b0;
    wk_waddr      = kept_r[AW-1:0];
    wk_wdata      = {cl_key, st_hit};
    wk_raddr      = idx_r[AW-1:0];

    // drop the result once taken
    if (ov_r && res_ready) begin
      ov_nxt = 1'b0;
    end

    // configuration writes to a defined index clear the built flag
    if (cfg_we) begin
      case (cfg_index)
        hrb_pkg::CFG_UB0, hrb_pkg::CFG_UB1, hrb_pkg::CFG_UB2, hrb_pkg::CFG_UB3: begin
          ub_nxt[cfg_index[1:0]] = cfg_data;
          built_nxt = 1'b0;
        end
        hrb_pkg::CFG_NBINS: begin
          nbins_nxt = cfg_data[2:0];
          built_nxt = 1'b0;
        end
        hrb_pkg::CFG_YBASE: begin
          ybase_nxt = cfg_data;
          built_nxt = 1'b0;
        end
        hrb_pkg::CFG_YSTEP: begin
          ystep_nxt = cfg_data[14:0];
          built_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    case (state_r)
      hrb_pkg::S_IDLE: begin
        if (pop_valid) begin
          pop       = 1'b1;
          item_nxt  = pop_item;
          pstat_nxt = hrb_pkg::ST_OK;
          phit_nxt  = '0;
          first_nxt = '0;
          end_nxt   = '0;
          state_nxt = hrb_pkg::S_DONE;
          case (pop_item.op)
            hrb_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              drop_nxt  = '0;
              built_nxt = 1'b0;
              for (int r = 0; r < hrb_pkg::SLOTS; r++) rs_nxt[r] = '0;
            end
            hrb_pkg::OP_LOAD: begin
              if (cnt_r >= CW'(hrb_pkg::HIT_CAPACITY)) begin
                pstat_nxt = hrb_pkg::ST_FULL;
              end else begin
                st_we     = 1'b1;
                st_wdata  = pop_item.hit;
                cnt_nxt   = cnt_r + 1'b1;
                built_nxt = 1'b0;
              end
            end
            hrb_pkg::OP_BUILD: begin
              idx_nxt   = '0;
              kept_nxt  = '0;
              dcnt_nxt  = '0;
              state_nxt = hrb_pkg::S_CL_RD;
            end
            hrb_pkg::OP_QREGION, hrb_pkg::OP_QMIN, hrb_pkg::OP_QWIN: begin
              if (!built_r) begin
                pstat_nxt = hrb_pkg::ST_NOT_BUILT;
              end else if ({1'b0, pop_item.region} >= 5'(nb * hrb_pkg::Y_BANDS)) begin
                pstat_nxt = hrb_pkg::ST_BAD;
              end else begin
                state_nxt = hrb_pkg::S_QA;
              end
            end
            hrb_pkg::OP_READ: begin
              if ({1'b0, pop_item.read_index} >= cnt_r) begin
                pstat_nxt = hrb_pkg::ST_BAD;
              end else begin
                st_raddr  = pop_item.read_index;
                state_nxt = hrb_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      hrb_pkg::S_READ: begin
        phit_nxt  = st_hit;
        state_nxt = hrb_pkg::S_DONE;
      end

      // look up the region bounds
      hrb_pkg::S_QA: begin
        first_nxt = rs_r[item_r.region];
        state_nxt = hrb_pkg::S_QB;
      end

      hrb_pkg::S_QB: begin
        end_nxt = rs_r[5'(item_r.region) + 5'd1];
        if (item_r.op == hrb_pkg::OP_QREGION) begin
          state_nxt = hrb_pkg::S_DONE;
        end else begin
          state_nxt = hrb_pkg::S_MIN_RD;
        end
      end

      // advance the start past hits left of x_min
      hrb_pkg::S_MIN_RD: begin
        st_raddr = first_r[AW-1:0];
        if (first_r < end_r) begin
          state_nxt = hrb_pkg::S_MIN_CHK;
        end else if (item_r.op == hrb_pkg::OP_QWIN) begin
          last_nxt  = first_r;
          state_nxt = hrb_pkg::S_MAX_RD;
        end else begin
          state_nxt = hrb_pkg::S_DONE;
        end
      end

      hrb_pkg::S_MIN_CHK: begin
        if ($signed(lhs_min) > $signed(rhs_min)) begin
          if (item_r.op == hrb_pkg::OP_QWIN) begin
            last_nxt  = first_r;
            state_nxt = hrb_pkg::S_MAX_RD;
          end else begin
            state_nxt = hrb_pkg::S_DONE;
          end
        end else begin
          first_nxt = first_r + 1'b1;
          state_nxt = hrb_pkg::S_MIN_RD;
        end
      end

      // advance the end up to the first hit right of x_max
      hrb_pkg::S_MAX_RD: begin
        st_raddr = last_r[AW-1:0];
        if (last_r < end_r) begin
          state_nxt = hrb_pkg::S_MAX_CHK;
        end else begin
          end_nxt   = last_r;
          state_nxt = hrb_pkg::S_DONE;
        end
      end

      hrb_pkg::S_MAX_CHK: begin
        if ($signed(st_hit.x) > $signed(item_r.x_max)) begin
          end_nxt   = last_r;
          state_nxt = hrb_pkg::S_DONE;
        end else begin
          last_nxt  = last_r + 1'b1;
          state_nxt = hrb_pkg::S_MAX_RD;
        end
      end

      // build, pass one: classify and copy kept hits to the work RAM
      hrb_pkg::S_CL_RD: begin
        st_raddr = idx_r[AW-1:0];
        if (idx_r < cnt_r) begin
          state_nxt = hrb_pkg::S_CL_CHK;
        end else begin
          p_nxt         = '0;
          last_none_nxt = 1'b1;
          state_nxt     = hrb_pkg::S_SEL_INIT;
        end
      end

      hrb_pkg::S_CL_CHK: begin
        if (bin_ok && band_ok) begin
          wk_we    = 1'b1;
          kept_nxt = kept_r + 1'b1;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = hrb_pkg::S_CL_RD;
      end

      // build, pass two: select the next smallest key per output slot
      hrb_pkg::S_SEL_INIT: begin
        if (p_r < kept_r) begin
          idx_nxt       = '0;
          best_none_nxt = 1'b1;
          state_nxt     = hrb_pkg::S_SEL_RD;
        end else begin
          for (int r = 0; r < hrb_pkg::SLOTS; r++) begin
            if (last_none_r || (5'(r) > {1'b0, last_rg})) rs_nxt[r] = kept_r;
          end
          cnt_nxt   = kept_r;
          drop_nxt  = (drop_sum > 10'd511) ? 9'd511 : drop_sum[8:0];
          built_nxt = 1'b1;
          pstat_nxt = (dcnt_r != '0) ? hrb_pkg::ST_DROPPED : hrb_pkg::ST_OK;
          state_nxt = hrb_pkg::S_DONE;
        end
      end

      hrb_pkg::S_SEL_RD: begin
        wk_raddr = idx_r[AW-1:0];
        if (idx_r < kept_r) begin
          state_nxt = hrb_pkg::S_SEL_CHK;
        end else begin
          st_we    = 1'b1;
          st_waddr = p_r[AW-1:0];
          st_wdata = best_hit_r;
          for (int r = 0; r < hrb_pkg::SLOTS; r++) begin
            if ((last_none_r || (5'(r) > {1'b0, last_rg})) &&
                (5'(r) <= {1'b0, best_rg})) begin
              rs_nxt[r] = p_r;
            end
          end
          last_key_nxt  = best_key_r;
          last_none_nxt = 1'b0;
          p_nxt         = p_r + 1'b1;
          state_nxt     = hrb_pkg::S_SEL_INIT;
        end
      end

      hrb_pkg::S_SEL_CHK: begin
        if ((last_none_r || (tup > last_key_r)) && (best_none_r || (tup < best_key_r))) begin
          best_key_nxt  = tup;
          best_hit_nxt  = wk_hit;
          best_none_nxt = 1'b0;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = hrb_pkg::S_SEL_RD;
      end

      // hand the result to the output register
      hrb_pkg::S_DONE: begin
        if (!ov_r || res_ready) begin
          ov_nxt                = 1'b1;
          res_nxt.status        = pstat_r;
          res_nxt.first_index   = (pstat_r == hrb_pkg::ST_OK) ? first_r : '0;
          res_nxt.end_index     = (pstat_r == hrb_pkg::ST_OK) ? end_r : '0;
          res_nxt.hit           = phit_r;
          res_nxt.hit_count     = cnt_r;
          res_nxt.dropped_count = drop_r;
          state_nxt             = hrb_pkg::S_IDLE;
        end
      end

      default: state_nxt = hrb_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrb_pkg::S_IDLE;
      cnt_r   <= '0;
      drop_r  <= '0;
      built_r <= 1'b0;
      for (int r = 0; r < hrb_pkg::SLOTS; r++) rs_r[r] <= '0;
      for (int b = 0; b < hrb_pkg::X_BINS; b++) ub_r[b] <= '0;
      nbins_r <= 3'(hrb_pkg::X_BINS);
      ybase_r <= '0;
      ystep_r <= 15'd1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      built_r <= built_nxt;
      rs_r    <= rs_nxt;
      ub_r    <= ub_nxt;
      nbins_r <= nbins_nxt;
      ybase_r <= ybase_nxt;
      ystep_r <= ystep_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    idx_r       <= idx_nxt;
    p_r         <= p_nxt;
    kept_r      <= kept_nxt;
    dcnt_r      <= dcnt_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    end_r       <= end_nxt;
    best_key_r  <= best_key_nxt;
    best_hit_r  <= best_hit_nxt;
    best_none_r <= best_none_nxt;
    last_key_r  <= last_key_nxt;
    last_none_r <= last_none_nxt;
    pstat_r     <= pstat_nxt;
    phit_r      <= phit_nxt;
    res_r       <= res_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/hit_region_binner_range_query_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hit_region_binner_range_query_top
// Hit store with region build and index range queries.
// ----------------------------------------------------------------------------
// Usage: command words enter on in_ch (valid/ready) and every word yields one
// result word on out_ch. The cfg_ port writes the bin boundaries, bin count,
// band base and band height; the user must write them only while the block is
// idle, which the block itself does not enforce. A write to any defined index
// clears built. A two-word queue parts the front from the executing back end,
// and a result register holds the word until out_ch.ready, so stalls on one
// side do not stop the other until the queue fills. Query scans probe the hits
// through the one store RAM read port.
// Words are executed one at a time in order.
// Reset: counters, region table and built flag clear at once; the hit store
// has no clearing pass since only written entries are ever read.
// ----------------------------------------------------------------------------
module hit_region_binner_range_query_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hrb_pkg::CFG_DATA_W-1:0] cfg_data,
  hrb_in_if.sink                              in_ch,
  hrb_out_if.source                           out_ch
);

  logic             push_valid, push_ready, pop_valid, pop, res_valid;
  hrb_pkg::item_t   push_item, pop_item;
  hrb_pkg::result_t res;

  hrb_front u_front (
    .in_ch(in_ch), .push_valid(push_valid), .push_item(push_item),
    .push_ready(push_ready)
  );

  hrb_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_valid(push_valid), .push_item(push_item),
    .push_ready(push_ready), .pop_valid(pop_valid), .pop_item(pop_item), .pop(pop)
  );

  hrb_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pop_valid(pop_valid), .pop_item(pop_item), .pop(pop),
    .res_valid(res_valid), .res(res), .res_ready(out_ch.ready)
  );

  // drive the result channel
  assign out_ch.valid         = res_valid;
  assign out_ch.status        = res.status;
  assign out_ch.first_index   = res.first_index;
  assign out_ch.end_index     = res.end_index;
  assign out_ch.out_x         = res.hit.x;
  assign out_ch.out_width     = res.hit.dx;
  assign out_ch.out_y         = res.hit.y;
  assign out_ch.out_tag       = res.hit.tag;
  assign out_ch.hit_count     = res.hit_count;
  assign out_ch.dropped_count = res.dropped_count;

endmodule
`default_nettype wire
